>>> src/vtis_pkg.sv
package vtis_pkg;

   // Defaults and fixed encodings
   localparam int          VTIS_TABLE_ENTRIES = 16;
   localparam int          VTIS_PORT_COUNT    = 16;
   localparam int          VTIS_QUEUE_DEPTH   = 4;
   localparam logic [15:0] VTIS_BASE_RESET    = 16'h7077;
   localparam logic [15:0] VTIS_ETYPE_IPV4    = 16'h0800;
   localparam logic [0:0]  VTIS_CMD_TX        = 1'b0;

   // Register indexes
   localparam logic [2:0] CSR_BASE_ETHERTYPE = 3'd0;
   localparam logic [2:0] CSR_PACK_IP_ENABLE = 3'd1;
   localparam logic [2:0] CSR_TABLE_WORD_0   = 3'd2;
   localparam logic [2:0] CSR_TABLE_WORD_1   = 3'd3;
   localparam logic [2:0] CSR_TABLE_WORD_2   = 3'd4;
   localparam logic [2:0] CSR_TABLE_WORD_3   = 3'd5;

   typedef enum logic [1:0] {
      MODE_HEADER   = 2'd0,
      MODE_TAG_TAIL = 2'd1,
      MODE_PASS     = 2'd2
   } vtis_mode_type;

   typedef struct packed {
      logic       command;
      logic [3:0] port;
      logic [3:0] entry;
      logic [7:0] data_byte;
      logic       last;
   } vtis_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] out_port;
      logic [3:0] out_entry;
      logic       out_last;
   } vtis_rsp_type;

   // One queued job: a pass-through byte, or a header burst of 12 MAC bytes
   // followed by 2 or 6 suffix bytes
   typedef struct packed {
      logic            is_hdr;
      logic            last;
      logic [3:0]      port;
      logic [3:0]      entry;
      logic [7:0]      data_byte;
      logic            sfx_six;
      logic [5:0][7:0] sfx;
   } vtis_job_type;

endpackage

>>> src/vtis_fifo.sv
module vtis_fifo import vtis_pkg::*; #(
   parameter int DEPTH = VTIS_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  vtis_job_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output vtis_job_type head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   vtis_job_type   mem_ff [DEPTH];
   logic [AW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rp_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

>>> src/vtis_front.sv
module vtis_front import vtis_pkg::*; #(
   parameter int TABLE_ENTRIES = VTIS_TABLE_ENTRIES,
   parameter int PORT_COUNT    = VTIS_PORT_COUNT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         req_valid,
   output logic         req_ready,
   input  vtis_req_type req_data,
   output logic         push,
   output vtis_job_type push_data,
   input  logic         queue_full,
   input  logic         hdr_done,
   input  logic [3:0]   hs_rd_addr,
   output logic [7:0]   hs_rd_data
);

   logic [15:0]   base_ff;
   logic          pack_ff;
   logic [63:0]   tbl_ff [4];

   logic [7:0]    hs_ff [16];
   logic [4:0]    cnt_ff, cnt_in;
   vtis_mode_type mode_ff, mode_in;
   logic [3:0]    matched_ff, matched_in;
   logic          drop_ff, drop_in;
   logic          pend_ff, pend_in;

   logic [15:0]   ent_w [16];
   logic [15:0]   live;
   logic          acc, clr, hs_we;
   logic [3:0]    hs_addr;
   logic [15:0]   et, pv, tv;
   logic [11:0]   key_vid;
   logic          key_ok, hit;
   logic [3:0]    hit_idx;

   // Unpack table entries and their live flags
   for (genvar i = 0; i < 16; i++) begin : g_ent
      assign ent_w[i] = tbl_ff[i / 4][(i % 4) * 16 +: 16];
      assign live[i]  = (i < TABLE_ENTRIES) && (ent_w[i][11:0] != 12'd0)
                        && ({1'b0, ent_w[i][15:12]} < 5'(PORT_COUNT));
   end

   assign hs_rd_data = hs_ff[hs_rd_addr];
   assign req_ready  = !queue_full && !(pend_ff && (mode_ff != MODE_PASS));
   assign acc        = req_valid && req_ready;

   assign et = {hs_ff[12], req_data.data_byte};
   assign pv = et - base_ff;
   assign tv = base_ff + {4'd0, ent_w[req_data.entry][11:0]};

   // Pick the lookup key: tag TCI or packed ethertype offset
   always_comb begin
      if (mode_ff == MODE_TAG_TAIL) begin
         key_vid = {hs_ff[12][3:0], hs_ff[13]};
         key_ok  = 1'b1;
      end else begin
         key_vid = pv[11:0];
         key_ok  = (pv[15:12] == 4'd0);
      end
   end

   // Lowest live entry matching port and VID
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 15; i >= 0; i--) begin
         if (live[i] && ent_w[i][15:12] == req_data.port && ent_w[i][11:0] == key_vid) begin
            hit     = key_ok;
            hit_idx = 4'(i);
         end
      end
   end

   // Classify each beat and build queue jobs
   always_comb begin
      cnt_in     = cnt_ff;
      mode_in    = mode_ff;
      matched_in = matched_ff;
      drop_in    = drop_ff;
      pend_in    = pend_ff && !hdr_done;
      push       = 1'b0;
      push_data  = '0;
      hs_we      = 1'b0;
      hs_addr    = cnt_ff[3:0];
      clr        = 1'b0;
      push_data.last = req_data.last;
      if (acc) begin
         clr = req_data.last;
         if (!drop_ff) begin
            unique case (mode_ff)
               MODE_PASS: begin
                  push                = 1'b1;
                  push_data.data_byte = req_data.data_byte;
                  push_data.port      = ent_w[matched_ff][15:12];
                  push_data.entry     = matched_ff;
               end
               MODE_TAG_TAIL: begin
                  if (cnt_ff < 5'd17) begin
                     hs_we   = 1'b1;
                     hs_addr = cnt_ff[3:0] - 4'd2;
                     cnt_in  = cnt_ff + 5'd1;
                  end else if (!hit) begin
                     drop_in = 1'b1;
                  end else begin
                     matched_in       = hit_idx;
                     push             = 1'b1;
                     push_data.is_hdr = 1'b1;
                     push_data.port   = ent_w[hit_idx][15:12];
                     push_data.entry  = hit_idx;
                     push_data.sfx[0] = hs_ff[14];
                     push_data.sfx[1] = req_data.data_byte;
                     mode_in          = MODE_PASS;
                  end
               end
               MODE_HEADER: begin
                  hs_we = 1'b1;
                  if (cnt_ff < 5'd13) begin
                     cnt_in = cnt_ff + 5'd1;
                  end else begin
                     cnt_in = 5'd14;
                     if (req_data.command == VTIS_CMD_TX) begin
                        if (!live[req_data.entry]) begin
                           drop_in = 1'b1;
                        end else begin
                           matched_in       = req_data.entry;
                           push             = 1'b1;
                           push_data.is_hdr = 1'b1;
                           push_data.port   = ent_w[req_data.entry][15:12];
                           push_data.entry  = req_data.entry;
                           mode_in          = MODE_PASS;
                           if (pack_ff && et == VTIS_ETYPE_IPV4) begin
                              push_data.sfx[0] = tv[15:8];
                              push_data.sfx[1] = tv[7:0];
                           end else begin
                              push_data.sfx_six = 1'b1;
                              push_data.sfx[0]  = base_ff[15:8];
                              push_data.sfx[1]  = base_ff[7:0];
                              push_data.sfx[2]  = {4'd0, ent_w[req_data.entry][11:8]};
                              push_data.sfx[3]  = ent_w[req_data.entry][7:0];
                              push_data.sfx[4]  = hs_ff[12];
                              push_data.sfx[5]  = req_data.data_byte;
                           end
                        end
                     end else if (et == base_ff) begin
                        mode_in = MODE_TAG_TAIL;
                     end else if (pack_ff && hit) begin
                        matched_in       = hit_idx;
                        push             = 1'b1;
                        push_data.is_hdr = 1'b1;
                        push_data.port   = ent_w[hit_idx][15:12];
                        push_data.entry  = hit_idx;
                        push_data.sfx[0] = VTIS_ETYPE_IPV4[15:8];
                        push_data.sfx[1] = VTIS_ETYPE_IPV4[7:0];
                        mode_in          = MODE_PASS;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
               end
               default: begin
                  mode_in = MODE_HEADER;
               end
            endcase
         end
         if (clr) begin
            cnt_in  = '0;
            mode_in = MODE_HEADER;
            drop_in = 1'b0;
         end
      end
      if (push && push_data.is_hdr) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         mode_ff    <= MODE_HEADER;
         matched_ff <= '0;
         drop_ff    <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         mode_ff    <= mode_in;
         matched_ff <= matched_in;
         drop_ff    <= drop_in;
         pend_ff    <= pend_in;
      end
   end

   // Hold header bytes
   always_ff @(posedge clock) begin
      if (hs_we) begin
         hs_ff[hs_addr] <= req_data.data_byte;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= VTIS_BASE_RESET;
         pack_ff   <= 1'b0;
         tbl_ff[0] <= '0;
         tbl_ff[1] <= '0;
         tbl_ff[2] <= '0;
         tbl_ff[3] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_ETHERTYPE: base_ff   <= csr_wdata[15:0];
            CSR_PACK_IP_ENABLE: pack_ff   <= csr_wdata[0];
            CSR_TABLE_WORD_0:   tbl_ff[0] <= csr_wdata;
            CSR_TABLE_WORD_1:   tbl_ff[1] <= csr_wdata;
            CSR_TABLE_WORD_2:   tbl_ff[2] <= csr_wdata;
            CSR_TABLE_WORD_3:   tbl_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

>>> src/vtis_back.sv
module vtis_back import vtis_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  vtis_job_type head_data,
   output logic         pop,
   output logic         hdr_done,
   output logic [3:0]   hs_rd_addr,
   input  logic [7:0]   hs_rd_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output vtis_rsp_type rsp_data
);

   logic [4:0]   cnt_ff, cnt_in;
   logic         rv_ff, rv_in;
   vtis_rsp_type rsp_ff, rsp_in;
   logic         adv, fin;
   logic [2:0]   k;

   assign hs_rd_addr = cnt_ff[3:0];
   assign k          = 3'(cnt_ff - 5'd12);
   assign adv        = head_valid && (!rv_ff || rsp_ready);
   assign fin        = !head_data.is_hdr
                       || (cnt_ff == (head_data.sfx_six ? 5'd17 : 5'd13));
   assign pop        = adv && fin;
   assign hdr_done   = pop && head_data.is_hdr;
   assign rsp_valid  = rv_ff;
   assign rsp_data   = rsp_ff;

   // Expand the head job into the output register, one beat per cycle unless rsp_ready stalls it
   always_comb begin
      cnt_in = cnt_ff;
      rv_in  = rv_ff && !rsp_ready;
      rsp_in = rsp_ff;
      if (adv) begin
         rv_in            = 1'b1;
         rsp_in.out_port  = head_data.port;
         rsp_in.out_entry = head_data.entry;
         rsp_in.out_last  = head_data.last && fin;
         if (!head_data.is_hdr) begin
            rsp_in.out_byte = head_data.data_byte;
         end else if (cnt_ff < 5'd12) begin
            rsp_in.out_byte = hs_rd_data;
         end else begin
            rsp_in.out_byte = head_data.sfx[k];
         end
         cnt_in = fin ? 5'd0 : cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

>>> src/vlan_tag_insert_strip.sv
// VLAN tag insert/strip with a configurable tag ethertype.
// Input channel req_*: one frame byte per beat, destination MAC first, with
// command, port, entry and last. Output channel rsp_*: one rewritten byte per
// beat with its physical port, interface entry and last flag.
// csr_*: write-only registers (base ethertype, pack enable, four table words),
// to be written by the user only while the block is idle; the block does not enforce it.
// Throughput: one input byte per cycle while req_ready is high. Header bytes
// are held (no output) until the decision byte; the header burst of 14 or 18
// beats then leaves the output at one beat per cycle, and pass-through bytes
// follow at one per cycle, while rsp_ready is high. The job queue between the
// classifier and the expander absorbs the burst; while a header burst is still
// being sent, the next frame's header bytes wait. Jobs pass through the queue,
// then the output register. Unmatched, empty or short frames give no output.
// Reset (synchronous) empties the queue, clears the output valid flag and
// restores register defaults. When rsp_ready is low the output beat holds,
// the queue fills, and req_ready drops once the queue is full.
module vlan_tag_insert_strip import vtis_pkg::*; #(
   parameter int TABLE_ENTRIES = VTIS_TABLE_ENTRIES,
   parameter int PORT_COUNT    = VTIS_PORT_COUNT,
   parameter int QUEUE_DEPTH   = VTIS_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         req_valid,
   output logic         req_ready,
   input  vtis_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output vtis_rsp_type rsp_data
);

   logic         push, full, pop, head_valid, hdr_done;
   vtis_job_type push_data, head_data;
   logic [3:0]   hs_rd_addr;
   logic [7:0]   hs_rd_data;

   vtis_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .PORT_COUNT   (PORT_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .queue_full(full),
      .hdr_done  (hdr_done),
      .hs_rd_addr(hs_rd_addr),
      .hs_rd_data(hs_rd_data)
   );

   vtis_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   vtis_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_data (head_data),
      .pop       (pop),
      .hdr_done  (hdr_done),
      .hs_rd_addr(hs_rd_addr),
      .hs_rd_data(hs_rd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
